// File: hw/rtl/rcpe_pkg.sv
// ----------------------------------------------------------------------------
// rcpe_pkg
// Shared types and constants for the remote code pulse encoder.
// ----------------------------------------------------------------------------
package rcpe_pkg;

    localparam int WIDTH_W    = 15;
    localparam int BASE_W     = 16;
    localparam int MULT_W     = 6;
    localparam int PROD_W     = BASE_W + MULT_W;
    localparam int CODE_W     = 32;
    localparam int SYM_W      = 8;
    localparam int REP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int LONG_W     = 4;
    localparam int SYNC_W     = 6;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 32'h00FF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MULT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MULT = 3'd3;

    localparam logic [WIDTH_W-1:0] MIN_BASE_RST  = 15'd100;
    localparam logic [WIDTH_W-1:0] MAX_BASE_RST  = 15'd1000;
    localparam logic [LONG_W-1:0]  LONG_MULT_RST = 4'd3;
    localparam logic [SYNC_W-1:0]  SYNC_MULT_RST = 6'd31;

    typedef struct packed {
        logic [WIDTH_W-1:0] min_base;
        logic [WIDTH_W-1:0] max_base;
        logic [LONG_W-1:0]  long_mult;
        logic [SYNC_W-1:0]  sync_mult;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] a;
        logic [MULT_W-1:0] b;
    } mul_req_t;

endpackage

// File: hw/rtl/rcpe_cfg.sv
// ----------------------------------------------------------------------------
// rcpe_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rcpe_cfg
    import rcpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_BASE:  cfg_next.min_base  = cfg_wr_data[WIDTH_W-1:0];
                REG_MAX_BASE:  cfg_next.max_base  = cfg_wr_data[WIDTH_W-1:0];
                REG_LONG_MULT: cfg_next.long_mult = cfg_wr_data[LONG_W-1:0];
                REG_SYNC_MULT: cfg_next.sync_mult = cfg_wr_data[SYNC_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_base  <= MIN_BASE_RST;
            cfg_reg.max_base  <= MAX_BASE_RST;
            cfg_reg.long_mult <= LONG_MULT_RST;
            cfg_reg.sync_mult <= SYNC_MULT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/rcpe_mul.sv
// ----------------------------------------------------------------------------
// rcpe_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rcpe_mul
    import rcpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(MULT_W);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [PROD_W-1:0] acc_reg,  acc_next;
    logic [PROD_W-1:0] a_reg,    a_next;
    logic [MULT_W-1:0] b_reg,    b_next;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            a_next   = PROD_W'(req.a);
            b_next   = req.b;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = {a_reg[PROD_W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[MULT_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MULT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(run_reg))
        else $error("multiplier done without a running product");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("multiplier done held longer than one cycle");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !run_reg)
        else $error("multiplier still running when done");

endmodule

// File: hw/rtl/remote_code_pulse_encoder.sv
// ----------------------------------------------------------------------------
// remote_code_pulse_encoder
// Validates a transmit request and emits its pulse train, or a single result
// when the request is rejected.
// Sequence: the long and sync widths are formed in turn as shift-add
//   products on the shared multiplier, then checked; a rejected request
//   gives its single result, an accepted one its pulse train, one pulse
//   per cycle. A new request is accepted only while the sequencer is
//   idle, once the last result of the request before has been shown.
// Reset: rst_n clears the sequencer and loads register defaults.
// Results cannot be stalled: each is shown for one cycle with pulse_valid.
module remote_code_pulse_encoder
    import rcpe_pkg::*;
#(
    parameter int CODE_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CODE_W-1:0]     code_word,
    input  logic [SYM_W-1:0]      symbol_count,
    input  logic [BASE_W-1:0]     base_pulse_us,
    input  logic [REP_W-1:0]      repeat_count,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output logic                  pulse_valid,
    output logic                  level_high,
    output logic [WIDTH_W-1:0]    width_us,
    output logic                  last_pulse,
    output logic                  rejected,
    output logic [REP_W-1:0]      repeats_out
);

    localparam int NUM_PULSES = 2 * CODE_BITS + 2;
    localparam int PCW        = $clog2(NUM_PULSES);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_LONG = 3'd1;
    localparam logic [2:0] ST_MUL_SYNC = 3'd2;
    localparam logic [2:0] ST_CHECK    = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    cfg_t              cfg;
    mul_req_t          mul_req;
    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;

    logic [2:0]           state_reg, state_next;
    logic [PCW-1:0]       cnt_reg,   cnt_next;
    logic [CODE_BITS-1:0] code_reg,  code_next;
    logic [CODE_W-1:0]    word_reg,  word_next;
    logic [SYM_W-1:0]     syms_reg,  syms_next;
    logic [BASE_W-1:0]    t_reg,     t_next;
    logic [REP_W-1:0]     reps_reg,  reps_next;
    logic [PROD_W-1:0]    tl_reg,    tl_next;
    logic [PROD_W-1:0]    ts_reg,    ts_next;

    logic                 valid_reg, valid_next;
    logic                 level_reg, level_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic                 last_reg,  last_next;
    logic                 rej_reg,   rej_next;
    logic [REP_W-1:0]     rout_reg,  rout_next;

    logic accept;
    logic ok;
    logic bit_one;

    rcpe_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    rcpe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign bit_one = code_reg[CODE_BITS-1];

    // all widths must be in 1..32767
    assign ok = (syms_reg == SYM_W'(CODE_BITS))
             && (t_reg >= BASE_W'(cfg.min_base))
             && (t_reg <= BASE_W'(cfg.max_base))
             && (reps_reg != '0)
             && (word_reg <= CODE_LIMIT)
             && (t_reg != '0) && !t_reg[BASE_W-1]
             && (tl_reg != '0) && (tl_reg[PROD_W-1:WIDTH_W] == '0)
             && (ts_reg != '0) && (ts_reg[PROD_W-1:WIDTH_W] == '0);

    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = t_reg;
        mul_req.b     = MULT_W'(cfg.sync_mult);
        if (accept)
        begin
            mul_req.start = 1'b1;
            mul_req.a     = base_pulse_us;
            mul_req.b     = MULT_W'(cfg.long_mult);
        end
        else if (state_reg == ST_MUL_LONG && mul_done)
        begin
            mul_req.start = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        word_next  = word_reg;
        syms_next  = syms_reg;
        t_next     = t_reg;
        reps_next  = reps_reg;
        tl_next    = tl_reg;
        ts_next    = ts_reg;
        valid_next = 1'b0;
        level_next = level_reg;
        width_next = width_reg;
        last_next  = last_reg;
        rej_next   = rej_reg;
        rout_next  = rout_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    word_next  = code_word;
                    code_next  = code_word[CODE_BITS-1:0];
                    syms_next  = symbol_count;
                    t_next     = base_pulse_us;
                    reps_next  = repeat_count;
                    state_next = ST_MUL_LONG;
                end
            end
            ST_MUL_LONG:
            begin
                if (mul_done)
                begin
                    tl_next    = mul_prod;
                    state_next = ST_MUL_SYNC;
                end
            end
            ST_MUL_SYNC:
            begin
                if (mul_done)
                begin
                    ts_next    = mul_prod;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ok)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    valid_next = 1'b1;
                    level_next = 1'b0;
                    width_next = '0;
                    last_next  = 1'b1;
                    rej_next   = 1'b1;
                    rout_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                rej_next   = 1'b0;
                last_next  = 1'b0;
                rout_next  = '0;
                level_next = !cnt_reg[0];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == PCW'(NUM_PULSES - 1))
                begin
                    // sync low
                    width_next = ts_reg[WIDTH_W-1:0];
                    last_next  = 1'b1;
                    rout_next  = reps_reg;
                    state_next = ST_IDLE;
                end
                else if (cnt_reg == PCW'(NUM_PULSES - 2))
                begin
                    width_next = t_reg[WIDTH_W-1:0];
                end
                else if (!cnt_reg[0])
                begin
                    width_next = bit_one ? tl_reg[WIDTH_W-1:0] : t_reg[WIDTH_W-1:0];
                end
                else
                begin
                    width_next = bit_one ? t_reg[WIDTH_W-1:0] : tl_reg[WIDTH_W-1:0];
                    code_next  = code_reg << 1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        word_reg  <= word_next;
        syms_reg  <= syms_next;
        t_reg     <= t_next;
        reps_reg  <= reps_next;
        tl_reg    <= tl_next;
        ts_reg    <= ts_next;
        level_reg <= level_next;
        width_reg <= width_next;
        last_reg  <= last_next;
        rej_reg   <= rej_next;
        rout_reg  <= rout_next;
    end

    assign pulse_valid = valid_reg;
    assign level_high  = level_reg;
    assign width_us    = width_reg;
    assign last_pulse  = last_reg;
    assign rejected    = rej_reg;
    assign repeats_out = rout_reg;

    a_reject_item: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && rejected |-> last_pulse && width_us == '0 && !level_high)
        else $error("malformed rejected request result");

    a_pulse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && !rejected |-> width_us != '0)
        else $error("zero width pulse on accepted request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("sequencer not busy after accepting a request");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && last_pulse |-> !busy || $past(accept))
        else $error("last result while the request is still in progress");

endmodule

// File: tb/pulse_train_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_train_checker
// Watches the request, register and pulse ports of the remote code pulse
// encoder. It keeps a shadow of the registers, predicts the pulse train of
// every accepted request and compares each pulse, field by field, in order.
// ----------------------------------------------------------------------------
module pulse_train_checker
    import rcpe_pkg::*;
#(
    parameter int CODE_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [CODE_W-1:0]     code_word,
    input  logic [SYM_W-1:0]      symbol_count,
    input  logic [BASE_W-1:0]     base_pulse_us,
    input  logic [REP_W-1:0]      repeat_count,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  pulse_valid,
    input  logic                  level_high,
    input  logic [WIDTH_W-1:0]    width_us,
    input  logic                  last_pulse,
    input  logic                  rejected,
    input  logic [REP_W-1:0]      repeats_out,
    output int                    mismatches,
    output int                    pulses_pending
);

    localparam int unsigned MAX_WIDTH_US = 32767;

    typedef struct packed {
        logic               lvl_high;
        logic [WIDTH_W-1:0] width;
        logic               is_last;
        logic               is_rejected;
        logic [REP_W-1:0]   reps;
    } pulse_t;

    cfg_t   cfg_shadow;
    pulse_t pending_pulses[$];
    pulse_t want_pulse;
    int     fail_count = 0;

    function automatic bit width_in_range(input int unsigned w);
        return (w != 0) && (w <= MAX_WIDTH_US);
    endfunction

    task automatic push_pulse(input logic lvl, input int unsigned w, input logic fin,
                              input logic rej, input logic [REP_W-1:0] reps);
        pulse_t p;
        p.lvl_high    = lvl;
        p.width       = w[WIDTH_W-1:0];
        p.is_last     = fin;
        p.is_rejected = rej;
        p.reps        = reps;
        pending_pulses.push_back(p);
    endtask

    task automatic predict_pulse_train(input logic [CODE_W-1:0] code,
                                       input logic [SYM_W-1:0]  syms,
                                       input logic [BASE_W-1:0] base,
                                       input logic [REP_W-1:0]  reps);
        int unsigned t;
        int unsigned t_long;
        int unsigned t_sync;
        bit          ok;
        t      = 32'(base);
        t_long = t * cfg_shadow.long_mult;
        t_sync = t * cfg_shadow.sync_mult;
        ok = (syms == CODE_BITS) && (t >= cfg_shadow.min_base) &&
             (t <= cfg_shadow.max_base) && (reps != 0) && (code <= CODE_LIMIT) &&
             width_in_range(t) && width_in_range(t_long) && width_in_range(t_sync);
        if (!ok)
        begin
            push_pulse(1'b0, 0, 1'b1, 1'b1, '0);
        end
        else
        begin
            for (int b = CODE_BITS - 1; b >= 0; b--)
            begin
                if (code[b])
                begin
                    push_pulse(1'b1, t_long, 1'b0, 1'b0, '0);
                    push_pulse(1'b0, t, 1'b0, 1'b0, '0);
                end
                else
                begin
                    push_pulse(1'b1, t, 1'b0, 1'b0, '0);
                    push_pulse(1'b0, t_long, 1'b0, 1'b0, '0);
                end
            end
            push_pulse(1'b1, t, 1'b0, 1'b0, '0);
            push_pulse(1'b0, t_sync, 1'b1, 1'b0, reps);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_shadow.min_base  = MIN_BASE_RST;
            cfg_shadow.max_base  = MAX_BASE_RST;
            cfg_shadow.long_mult = LONG_MULT_RST;
            cfg_shadow.sync_mult = SYNC_MULT_RST;
            pending_pulses.delete();
            pulses_pending <= 0;
        end
        else
        begin
            if (pulse_valid)
            begin
                if (pending_pulses.size() == 0)
                begin
                    $error("pulse with no request pending: level_high %0d width_us %0d",
                           level_high, width_us);
                    fail_count++;
                end
                else
                begin
                    want_pulse = pending_pulses.pop_front();
                    check_field("level_high", 32'(want_pulse.lvl_high), 32'(level_high));
                    check_field("width_us", 32'(want_pulse.width), 32'(width_us));
                    check_field("last_pulse", 32'(want_pulse.is_last), 32'(last_pulse));
                    check_field("rejected", 32'(want_pulse.is_rejected), 32'(rejected));
                    check_field("repeats_out", 32'(want_pulse.reps), 32'(repeats_out));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MIN_BASE:  cfg_shadow.min_base  = cfg_wr_data[WIDTH_W-1:0];
                    REG_MAX_BASE:  cfg_shadow.max_base  = cfg_wr_data[WIDTH_W-1:0];
                    REG_LONG_MULT: cfg_shadow.long_mult = cfg_wr_data[LONG_W-1:0];
                    REG_SYNC_MULT: cfg_shadow.sync_mult = cfg_wr_data[SYNC_W-1:0];
                    default:       ;
                endcase
            end
            if (start && !busy)
                predict_pulse_train(code_word, symbol_count, base_pulse_us, repeat_count);
            pulses_pending <= pending_pulses.size();
        end
        mismatches <= fail_count;
    end

endmodule

// File: tb/tb_remote_code_pulse_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_remote_code_pulse_encoder
// Drives transmit requests and register writes into the remote code pulse
// encoder: directed corner requests over several register settings, then
// random register settings with mostly well-formed random requests and some
// broken ones. A checker beside the block predicts and compares each pulse.
// ----------------------------------------------------------------------------
module tb_remote_code_pulse_encoder;
    import rcpe_pkg::*;

    localparam int CODE_BITS    = 24;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RANDOM_SETS  = 6;
    localparam int SET_REQUESTS = 80;

    localparam logic [SYM_W-1:0] SYM_COUNT = SYM_W'(CODE_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  start         = 1'b0;
    logic [CODE_W-1:0]     code_word     = '0;
    logic [SYM_W-1:0]      symbol_count  = '0;
    logic [BASE_W-1:0]     base_pulse_us = '0;
    logic [REP_W-1:0]      repeat_count  = '0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  busy;
    logic                  pulse_valid;
    logic                  level_high;
    logic [WIDTH_W-1:0]    width_us;
    logic                  last_pulse;
    logic                  rejected;
    logic [REP_W-1:0]      repeats_out;
    int                    mismatches;
    int                    pulses_pending;

    int unsigned cur_min = 32'(MIN_BASE_RST);
    int unsigned cur_max = 32'(MAX_BASE_RST);

    always #6 clk = ~clk;

    remote_code_pulse_encoder #(.CODE_BITS(CODE_BITS)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .code_word     (code_word),
        .symbol_count  (symbol_count),
        .base_pulse_us (base_pulse_us),
        .repeat_count  (repeat_count),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .pulse_valid   (pulse_valid),
        .level_high    (level_high),
        .width_us      (width_us),
        .last_pulse    (last_pulse),
        .rejected      (rejected),
        .repeats_out   (repeats_out)
    );

    pulse_train_checker #(.CODE_BITS(CODE_BITS)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .code_word      (code_word),
        .symbol_count   (symbol_count),
        .base_pulse_us  (base_pulse_us),
        .repeat_count   (repeat_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .pulse_valid    (pulse_valid),
        .level_high     (level_high),
        .width_us       (width_us),
        .last_pulse     (last_pulse),
        .rejected       (rejected),
        .repeats_out    (repeats_out),
        .mismatches     (mismatches),
        .pulses_pending (pulses_pending)
    );

    // returns at the edge that accepts the request
    task automatic send_request(input logic [CODE_W-1:0] code, input logic [SYM_W-1:0] syms,
                                input logic [BASE_W-1:0] t, input logic [REP_W-1:0] reps);
        start         <= 1'b1;
        code_word     <= code;
        symbol_count  <= syms;
        base_pulse_us <= t;
        repeat_count  <= reps;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        int cycles;
        cycles = 0;
        start <= 1'b0;
        @(posedge clk);
        while ((pulses_pending != 0 || busy) && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic program_regs(input int unsigned min_us, input int unsigned max_us,
                                input int unsigned long_m, input int unsigned sync_m);
        wait_drained();
        write_reg(REG_MIN_BASE, min_us);
        write_reg(REG_MAX_BASE, max_us);
        write_reg(REG_LONG_MULT, long_m);
        write_reg(REG_SYNC_MULT, sync_m);
        write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 3)),
                  $urandom_range(0, 32767));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        cur_min = min_us & 32'h7FFF;
        cur_max = max_us & 32'h7FFF;
    endtask

    task automatic pause_after_request(input bit idle_ok);
        if (idle_ok && $urandom_range(0, 49) == 0)
        begin
            wait_drained();
        end
        else if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    task automatic send_random_request(input bit idle_ok);
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  syms;
        logic [BASE_W-1:0] t;
        logic [REP_W-1:0]  reps;
        code = $urandom_range(0, 32'h00FF_FFFF);
        syms = SYM_COUNT;
        reps = REP_W'($urandom_range(1, 255));
        if (cur_min <= cur_max)
            t = BASE_W'($urandom_range(cur_min, cur_max));
        else
            t = BASE_W'($urandom_range(0, 2000));
        case ($urandom_range(0, 9))
            0: syms = SYM_W'($urandom_range(0, 255));
            1: t    = BASE_W'($urandom_range(0, 65535));
            2: reps = '0;
            3: code = $urandom();
            default: ;
        endcase
        send_request(code, syms, t, reps);
        pause_after_request(idle_ok);
    endtask

    initial
    begin
        int unsigned min_us;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults
        send_request(32'h0000_0000, SYM_COUNT, 16'd100, 8'd1);
        send_request(32'h00FF_FFFF, SYM_COUNT, 16'd1000, 8'd255);
        send_request(32'h00A5_C3F0, SYM_COUNT, 16'd99, 8'd1);
        send_request(32'h0012_3456, SYM_COUNT, 16'd1001, 8'd7);
        send_request(32'h005A_5A5A, 8'd23, 16'd500, 8'd3);
        send_request(32'h005A_5A5A, 8'd25, 16'd500, 8'd3);
        send_request(32'h005A_5A5A, SYM_COUNT, 16'd500, 8'd0);
        send_request(32'h0100_0000, SYM_COUNT, 16'd500, 8'd3);
        send_request(32'hFFFF_FFFF, SYM_COUNT, 16'd500, 8'd3);
        send_request(32'h0080_0001, 8'hFF, 16'hFFFF, 8'h80);
        send_request(32'h0000_0001, 8'd0, 16'd0, 8'd0);

        // widest range, largest multiples: sync low width limits T
        program_regs(1, 32767, 15, 63);
        send_request(32'h00FF_FFFF, SYM_COUNT, 16'd1, 8'd1);
        send_request(32'h00C0_FFEE, SYM_COUNT, 16'd520, 8'd9);
        send_request(32'h00C0_FFEE, SYM_COUNT, 16'd521, 8'd9);
        send_request(32'h000F_0F0F, SYM_COUNT, 16'd32767, 8'd9);
        send_request(32'h000F_0F0F, SYM_COUNT, 16'd0, 8'd9);

        // long data width limits T, zero T inside the range
        program_regs(0, 32767, 15, 1);
        send_request(32'h00FF_FFFF, SYM_COUNT, 16'd2184, 8'd2);
        send_request(32'h00FF_FFFF, SYM_COUNT, 16'd2185, 8'd2);
        send_request(32'h0000_FF00, SYM_COUNT, 16'd0, 8'd2);

        // zero multiples
        program_regs(0, 32767, 0, 0);
        send_request(32'h0012_3456, SYM_COUNT, 16'd100, 8'd1);

        // inverted range
        program_regs(500, 400, 3, 31);
        send_request(32'h0012_3456, SYM_COUNT, 16'd450, 8'd1);
        send_request(32'h0012_3456, SYM_COUNT, 16'd500, 8'd1);

        program_regs(32767, 32767, 15, 63);
        send_request(32'h0012_3456, SYM_COUNT, 16'd32767, 8'd1);

        // random settings; upper data bits of the multiples are don't-care
        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            min_us = $urandom_range(1, 200);
            program_regs(min_us, min_us + $urandom_range(0, 800),
                         ($urandom_range(0, 2047) << 4) | $urandom_range(1, 15),
                         ($urandom_range(0, 511) << 6) | $urandom_range(1, 63));
            for (int n = 0; n < SET_REQUESTS; n++)
                send_random_request(s != RANDOM_SETS - 1);
        end

        wait_drained();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0 && pulses_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rcpe_pkg.sv
hw/rtl/rcpe_cfg.sv
hw/rtl/rcpe_mul.sv
hw/rtl/remote_code_pulse_encoder.sv
tb/pulse_train_checker.sv
tb/tb_remote_code_pulse_encoder.sv
